// ===== src/mfrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrc_pkg
// Shared types and constants for the four-ray mask containment block.
// ----------------------------------------------------------------------------
package mfrc_pkg;

  localparam int CFG_W          = 10;
  localparam int COORD_W        = 9;
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [CFG_W-1:0] MASK_WIDTH_RST  = 10'd512;
  localparam logic [CFG_W-1:0] MASK_HEIGHT_RST = 10'd512;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic REG_MASK_WIDTH  = 1'b0;
  localparam logic REG_MASK_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_LEFT,
    DIR_DOWN,
    DIR_UP
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic step;
    logic capture;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic wr_ok;
    logic ray_hit;
    logic ray_miss;
    logic last_ray;
  } dp_stat_t;

endpackage

// ===== src/mfrc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfrc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mfrc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrc_ctrl
// Request sequencer: accepts writes and queries, runs the ray scan, hands
// the answer to the output register.
// ----------------------------------------------------------------------------
module mfrc_ctrl
  import mfrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_req_type,
  input  logic      out_tready,
  input  dp_stat_t  stat,
  output logic      in_tready,
  output logic      out_tvalid,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   slot_free;
  logic   scan_done;

  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign scan_done = !stat.range_ok || (stat.ray_hit && stat.last_ray) || stat.ray_miss;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_req_type == REQ_QUERY) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_xfer && in_req_type == REQ_QUERY;
        cmd.wr    = in_xfer && in_req_type == REQ_WRITE && stat.wr_ok;
      end
      ST_SCAN: begin
        cmd.step    = stat.range_ok;
        cmd.capture = scan_done;
      end
      ST_HOLD: begin
        cmd.push = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_tready))
    else $error("result pushed over a waiting result");

  a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SCAN)
    else $error("query load did not start a scan");

  a_oor_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !stat.range_ok) |=> state_r == ST_HOLD)
    else $error("out-of-area query kept scanning");

  a_capture_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !cmd.push && !in_tready)
    else $error("capture overlapped push or input transfer");
`endif

endmodule

// ===== src/mfrc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrc_dp
// Datapath: size registers, query coordinates, ray cursor, mask RAM and
// result registers.
// ----------------------------------------------------------------------------
module mfrc_dp
  import mfrc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  input  logic               in_pixel_on,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output dp_stat_t           stat,
  output logic               out_res
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int PW    = $clog2(MAXD);
  localparam int EWA   = $clog2(MAXD + 1);
  localparam int EW    = (EWA > CFG_W) ? EWA : CFG_W;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_W-1:0]   mask_width_r, mask_height_r;
  logic [COORD_W-1:0] qcol_r, qrow_r;
  logic               range_ok_r;
  dir_t               dir_r, dir_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               issue_r, issue_nxt;
  logic               chk_r, chk_nxt;
  logic               chk_last_r, chk_last_nxt;
  logic               res_r;
  logic               out_res_r;

  logic [EW-1:0] w_ext, h_ext, w_eff, h_eff;
  logic          is_end;
  logic          rdata;
  logic          ray_hit, ray_miss;
  logic [AW-1:0] waddr, raddr;

  assign w_ext = EW'(mask_width_r);
  assign h_ext = EW'(mask_height_r);
  assign w_eff = (w_ext > EW'(MAX_WIDTH))  ? EW'(MAX_WIDTH)  : w_ext;
  assign h_eff = (h_ext > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : h_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_width_r  <= MASK_WIDTH_RST;
      mask_height_r <= MASK_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASK_WIDTH:  mask_width_r  <= cfg_data;
        REG_MASK_HEIGHT: mask_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dir_r)
      DIR_RIGHT: is_end = EW'(pos_r) == w_eff - EW'(1);
      DIR_DOWN:  is_end = EW'(pos_r) == h_eff - EW'(1);
      default:   is_end = pos_r == '0;
    endcase
  end

  always_comb begin
    case (dir_r)
      DIR_RIGHT, DIR_LEFT: raddr = AW'(qrow_r) * AW'(MAX_WIDTH) + AW'(pos_r);
      default:             raddr = AW'(pos_r) * AW'(MAX_WIDTH) + AW'(qcol_r);
    endcase
  end

  assign waddr    = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
  assign ray_hit  = chk_r && rdata;
  assign ray_miss = chk_r && chk_last_r && !rdata;

  always_comb begin
    dir_nxt      = dir_r;
    pos_nxt      = pos_r;
    issue_nxt    = issue_r;
    chk_nxt      = chk_r;
    chk_last_nxt = chk_last_r;
    if (cmd.load) begin
      dir_nxt      = DIR_RIGHT;
      pos_nxt      = PW'(in_col);
      issue_nxt    = 1'b1;
      chk_nxt      = 1'b0;
      chk_last_nxt = 1'b0;
    end else if (cmd.step) begin
      if (ray_hit) begin
        issue_nxt    = 1'b1;
        chk_nxt      = 1'b0;
        chk_last_nxt = 1'b0;
        case (dir_r)
          DIR_RIGHT: begin
            dir_nxt = DIR_LEFT;
            pos_nxt = PW'(qcol_r);
          end
          DIR_LEFT: begin
            dir_nxt = DIR_DOWN;
            pos_nxt = PW'(qrow_r);
          end
          default: begin
            dir_nxt = DIR_UP;
            pos_nxt = PW'(qrow_r);
          end
        endcase
      end else begin
        chk_nxt      = issue_r;
        chk_last_nxt = issue_r && is_end;
        if (issue_r) begin
          if (is_end) begin
            issue_nxt = 1'b0;
          end else if (dir_r == DIR_RIGHT || dir_r == DIR_DOWN) begin
            pos_nxt = pos_r + PW'(1);
          end else begin
            pos_nxt = pos_r - PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r      <= DIR_RIGHT;
      issue_r    <= 1'b0;
      chk_r      <= 1'b0;
      chk_last_r <= 1'b0;
    end else begin
      dir_r      <= dir_nxt;
      issue_r    <= issue_nxt;
      chk_r      <= chk_nxt;
      chk_last_r <= chk_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load) begin
      qcol_r     <= in_col;
      qrow_r     <= in_row;
      range_ok_r <= (EW'(in_col) < w_eff) && (EW'(in_row) < h_eff);
    end
    if (cmd.capture) begin
      res_r <= ray_hit && dir_r == DIR_UP;
    end
    if (cmd.push) begin
      out_res_r <= res_r;
    end
  end

  mfrc_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_mask_ram (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(waddr),
    .wdata(in_pixel_on),
    .re   (cmd.step && issue_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign stat.range_ok = range_ok_r;
  assign stat.wr_ok    = (EW'(in_col) < EW'(MAX_WIDTH)) && (EW'(in_row) < EW'(MAX_HEIGHT));
  assign stat.ray_hit  = ray_hit;
  assign stat.ray_miss = ray_miss;
  assign stat.last_ray = dir_r == DIR_UP;
  assign out_res       = out_res_r;

endmodule

// ===== src/mask_four_ray_containment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_four_ray_containment
// Contour mask store with a four-ray point containment query.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | tdata: col, row, pixel_on; tuser: req_type
//   out_    | out | out_tvalid/tready   | tdata: inside_res
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (10 bits)
//
// A pixel write leaves the block idle, ready for the next request. A query
// scans its rays right, left, down and up in turn and takes no new request
// until its result is handed on; the single read port of the mask RAM
// delivers one pixel per cycle, and a ray stops at its first set pixel.
// A query outside the area in use ends without scanning the mask.
// The mask RAM is not cleared by reset; pixels are undefined until written.
// A stalled result waits in the output register; the next request is taken
// meanwhile, and a query holds only when it finishes before that result left.
// ----------------------------------------------------------------------------
module mask_four_ray_containment
  import mfrc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // col[8:0], row[17:9], pixel_on[18], zero
  input  logic             in_tuser,   // req_type[0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // inside_res[0], zero
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      out_res;

  assign cfg_ready = 1'b1;
  assign out_tdata = {7'b0, out_res};

  mfrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req_type(in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  mfrc_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_col     (in_tdata[8:0]),
    .in_row     (in_tdata[17:9]),
    .in_pixel_on(in_tdata[18]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .out_res    (out_res)
  );

endmodule
